// ----- rtl/core/ep0_req_pkg.sv -----
// Shared types, codes and helpers for the ep0 standard request handler.
package ep0_req_pkg;

    // Endpoint slot count default and configuration port geometry.
    localparam int EP_SLOTS_DEFAULT = 32;
    localparam int CFG_INDEX_W      = 2;
    localparam int CFG_DATA_W       = 1;
    localparam int SLOT_NUM_W       = 5;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_SELF_POWERED     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPEED_ABOVE_HIGH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FUNCTION_BOUND   = 2'd2;

    // Item operations.
    localparam logic [2:0] OP_SETUP     = 3'd0;
    localparam logic [2:0] OP_SW_ANSWER = 3'd1;
    localparam logic [2:0] OP_DATA_DONE = 3'd2;
    localparam logic [2:0] OP_SW_HALT   = 3'd3;
    localparam logic [2:0] OP_STATUS_GO = 3'd4;
    localparam logic [2:0] OP_BUS_EVENT = 3'd5;

    // Result actions.
    localparam logic [2:0] ACT_NONE  = 3'd0;
    localparam logic [2:0] ACT_STALL = 3'd1;
    localparam logic [2:0] ACT_ACK   = 3'd2;
    localparam logic [2:0] ACT_WORD  = 3'd3;
    localparam logic [2:0] ACT_FWD   = 3'd4;
    localparam logic [2:0] ACT_WAIT  = 3'd5;

    // Control transfer stages.
    localparam logic [1:0] ST_SETUP  = 2'd0;
    localparam logic [1:0] ST_DATA   = 2'd1;
    localparam logic [1:0] ST_STATUS = 2'd2;

    // Device states.
    localparam logic [1:0] DS_NOTATT     = 2'd0;
    localparam logic [1:0] DS_DEFAULT    = 2'd1;
    localparam logic [1:0] DS_ADDRESSED  = 2'd2;
    localparam logic [1:0] DS_CONFIGURED = 2'd3;

    // Kinds of request waiting on a software answer.
    localparam logic [1:0] PK_NONE     = 2'd0;
    localparam logic [1:0] PK_GENERIC  = 2'd1;
    localparam logic [1:0] PK_CFG_ZERO = 2'd2;
    localparam logic [1:0] PK_CFG_SET  = 2'd3;

    // Software answer codes.
    localparam logic [1:0] SW_OK      = 2'd0;
    localparam logic [1:0] SW_DELAYED = 2'd2;

    // Standard request codes and recipients.
    localparam logic [7:0] REQ_GET_STATUS    = 8'd0;
    localparam logic [7:0] REQ_CLEAR_FEATURE = 8'd1;
    localparam logic [7:0] REQ_SET_FEATURE   = 8'd3;
    localparam logic [7:0] REQ_SET_ADDRESS   = 8'd5;
    localparam logic [7:0] REQ_SET_CONFIG    = 8'd9;

    localparam logic [4:0] RCP_DEVICE    = 5'd0;
    localparam logic [4:0] RCP_INTERFACE = 5'd1;
    localparam logic [4:0] RCP_ENDPOINT  = 5'd2;

    // Feature selectors.
    localparam logic [15:0] FEAT_REMOTE_WAKEUP = 16'd1;
    localparam logic [15:0] FEAT_TEST_MODE     = 16'd2;
    localparam logic [7:0]  TEST_SEL_FIRST     = 8'd1;
    localparam logic [7:0]  TEST_SEL_LAST      = 8'd4;

    typedef struct packed {
        logic [2:0]  op;
        logic [7:0]  request_type;
        logic [7:0]  request_code;
        logic [15:0] value_word;
        logic [15:0] index_word;
        logic [15:0] length_word;
        logic [6:0]  hw_address;
        logic [1:0]  sw_result;
        logic        wedge_flag;
        logic        attached;
    } ep0_req_item_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [15:0] status_word;
        logic [1:0]  stage;
        logic [1:0]  usb_state;
        logic [6:0]  device_address;
    } ep0_req_result_t;

    // Endpoint slot: number 0 is slot 0, otherwise number * 2 + direction - 1.
    function automatic logic [SLOT_NUM_W-1:0] slot_of(input logic [15:0] windex);
        logic [SLOT_NUM_W-1:0] raw;
        raw = {windex[3:0], windex[7]};
        if (windex[3:0] == 4'd0) begin
            return '0;
        end
        return raw - SLOT_NUM_W'(1);
    endfunction

endpackage

// ----- rtl/core/ep0_req_if.sv -----
// Valid/ready channel interfaces for request items and result items.
interface ep0_req_item_if;
    import ep0_req_pkg::*;

    logic          valid;
    logic          ready;
    ep0_req_item_t item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

interface ep0_req_result_if;
    import ep0_req_pkg::*;

    logic            valid;
    logic            ready;
    ep0_req_result_t result;

    modport source (output valid, output result, input ready);
    modport sink (input valid, input result, output ready);
endinterface

// ----- rtl/core/usb_ep0_standard_request_handler.sv -----
// An accepted item goes into the input register, and its result into the result register.
// Throughput: one item per cycle; the only stall comes from the result register being held.
// All decoding and state update for an item happen combinationally between the two registers.
// Reset (rst_n low, asynchronous): stage setup, device not attached, address zero,
// wakeup, halt and wedge bits clear, nothing pending, configuration registers zero.
module usb_ep0_standard_request_handler #(
    parameter int ENDPOINT_SLOTS = ep0_req_pkg::EP_SLOTS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [ep0_req_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ep0_req_pkg::CFG_DATA_W-1:0]  cfg_data,
    ep0_req_item_if.sink                       req,
    ep0_req_result_if.source                   rsp
);
    import ep0_req_pkg::*;

    localparam int SLOT_W = $clog2(ENDPOINT_SLOTS);

    // Configuration registers.
    logic self_powered_reg;
    logic speed_above_high_reg;
    logic function_bound_reg;

    // Channel registers.
    ep0_req_item_t   item_reg;
    logic            item_valid_reg;
    ep0_req_result_t result_reg;
    logic            result_valid_reg;

    // Handler state.
    logic [1:0]                stage_reg, stage_next;
    logic [1:0]                dev_reg, dev_next;
    logic [6:0]                addr_reg, addr_next;
    logic                      wake_reg, wake_next;
    logic [ENDPOINT_SLOTS-1:0] halted_reg, halted_next;
    logic [ENDPOINT_SLOTS-1:0] wedged_reg, wedged_next;
    logic [1:0]                pend_reg, pend_next;

    logic [2:0]            act;
    logic [15:0]           word;
    logic                  do_stall;
    logic                  do_finish;
    logic                  feat_ok;
    logic                  set_ok;
    logic [SLOT_NUM_W-1:0] slot;
    logic                  slot_ok;
    logic [SLOT_W-1:0]     slot_idx;
    logic [4:0]            recip;
    logic                  is_set;
    logic                  advance;

    assign advance   = item_valid_reg && (!result_valid_reg || rsp.ready);
    assign req.ready = !item_valid_reg || advance;

    assign slot     = slot_of(item_reg.index_word);
    assign slot_ok  = {1'b0, slot} < (SLOT_NUM_W + 1)'(ENDPOINT_SLOTS);
    assign slot_idx = slot[SLOT_W-1:0];
    assign recip    = item_reg.request_type[4:0];
    assign is_set   = item_reg.request_code == REQ_SET_FEATURE;

    always_comb
    begin
        stage_next  = stage_reg;
        dev_next    = dev_reg;
        addr_next   = addr_reg;
        wake_next   = wake_reg;
        halted_next = halted_reg;
        wedged_next = wedged_reg;
        pend_next   = pend_reg;
        act         = ACT_NONE;
        word        = '0;
        do_stall    = 1'b0;
        do_finish   = 1'b0;
        feat_ok     = 1'b0;
        set_ok      = 1'b0;

        unique case (item_reg.op)
            OP_SETUP:
            begin
                if (!function_bound_reg) begin
                    do_finish = 1'b1;
                end else if (dev_reg == DS_NOTATT) begin
                    do_stall = 1'b1;
                end else begin
                    halted_next[0] = 1'b0;
                    pend_next      = PK_NONE;
                    stage_next     = (item_reg.length_word != 16'd0) ? ST_DATA : ST_STATUS;
                    // Follow the controller's address register when it moved on its own.
                    if (item_reg.request_code != REQ_SET_ADDRESS &&
                        addr_reg != item_reg.hw_address && dev_reg != DS_CONFIGURED) begin
                        addr_next = item_reg.hw_address;
                        dev_next  = (item_reg.hw_address != 7'd0) ? DS_ADDRESSED : DS_DEFAULT;
                    end
                    if (item_reg.request_type[6:5] != 2'd0) begin
                        pend_next = PK_GENERIC;
                        act       = ACT_FWD;
                    end else begin
                        unique case (item_reg.request_code) inside
                            REQ_SET_ADDRESS:
                            begin
                                set_ok = item_reg.value_word[15:7] == '0 &&
                                         dev_reg != DS_CONFIGURED;
                                if (set_ok) begin
                                    addr_next = item_reg.hw_address;
                                    dev_next  = (item_reg.value_word != 16'd0) ?
                                                DS_ADDRESSED : DS_DEFAULT;
                                    do_finish = 1'b1;
                                end else begin
                                    do_stall = 1'b1;
                                end
                            end
                            REQ_SET_CONFIG:
                            begin
                                if (dev_next < DS_ADDRESSED) begin
                                    do_stall = 1'b1;
                                end else begin
                                    pend_next = (item_reg.value_word != 16'd0) ?
                                                PK_CFG_SET : PK_CFG_ZERO;
                                    act       = ACT_FWD;
                                end
                            end
                            REQ_GET_STATUS:
                            begin
                                if (recip == RCP_DEVICE) begin
                                    word      = {14'd0, wake_reg, self_powered_reg};
                                    act       = ACT_WORD;
                                    do_finish = 1'b1;
                                end else if (recip == RCP_INTERFACE) begin
                                    pend_next = PK_GENERIC;
                                    act       = ACT_FWD;
                                end else if (recip == RCP_ENDPOINT && slot_ok) begin
                                    word      = {15'd0, halted_next[slot_idx]};
                                    act       = ACT_WORD;
                                    do_finish = 1'b1;
                                end else begin
                                    do_stall = 1'b1;
                                end
                            end
                            REQ_CLEAR_FEATURE, REQ_SET_FEATURE:
                            begin
                                if (recip == RCP_DEVICE) begin
                                    if (item_reg.value_word == FEAT_REMOTE_WAKEUP) begin
                                        wake_next = is_set;
                                        feat_ok   = 1'b1;
                                    end else if (item_reg.value_word == FEAT_TEST_MODE) begin
                                        feat_ok = dev_next == DS_CONFIGURED &&
                                                  !speed_above_high_reg && is_set &&
                                                  item_reg.index_word[7:0] == 8'd0 &&
                                                  item_reg.index_word[15:8] >= TEST_SEL_FIRST &&
                                                  item_reg.index_word[15:8] <= TEST_SEL_LAST;
                                    end
                                end else if (recip == RCP_INTERFACE) begin
                                    feat_ok = item_reg.value_word == 16'd0;
                                end else if (recip == RCP_ENDPOINT) begin
                                    feat_ok = item_reg.value_word == 16'd0 && slot_ok;
                                    // The ep0 address itself leaves the halt bits alone.
                                    if (feat_ok && (item_reg.index_word[15:8] != 8'd0 ||
                                                    item_reg.index_word[6:0] != 7'd0)) begin
                                        if (is_set) begin
                                            halted_next[slot_idx] = 1'b1;
                                        end else if (!wedged_reg[slot_idx]) begin
                                            halted_next[slot_idx] = 1'b0;
                                            wedged_next[slot_idx] = 1'b0;
                                        end
                                    end
                                end
                                if (feat_ok) begin
                                    do_finish = 1'b1;
                                end else begin
                                    do_stall = 1'b1;
                                end
                            end
                            default:
                            begin
                                pend_next = PK_GENERIC;
                                act       = ACT_FWD;
                            end
                        endcase
                    end
                end
            end
            OP_SW_ANSWER:
            begin
                if (pend_reg != PK_NONE) begin
                    pend_next = PK_NONE;
                    if (item_reg.sw_result == SW_DELAYED) begin
                        act = ACT_WAIT;
                    end else if (item_reg.sw_result != SW_OK) begin
                        do_stall = 1'b1;
                    end else begin
                        if (pend_reg == PK_CFG_ZERO) begin
                            dev_next = DS_ADDRESSED;
                        end else if (pend_reg == PK_CFG_SET) begin
                            dev_next = DS_CONFIGURED;
                        end
                        do_finish = 1'b1;
                    end
                end
            end
            OP_DATA_DONE:
            begin
                if (stage_reg == ST_DATA) begin
                    stage_next = ST_SETUP;
                    act        = ACT_ACK;
                end
            end
            OP_SW_HALT:
            begin
                if (slot == '0) begin
                    do_stall = 1'b1;
                end else if (slot_ok) begin
                    halted_next[slot_idx] = 1'b1;
                    if (item_reg.wedge_flag) begin
                        wedged_next[slot_idx] = 1'b1;
                    end
                end
            end
            OP_STATUS_GO:
            begin
                if (stage_reg == ST_STATUS) begin
                    stage_next = ST_SETUP;
                    dev_next   = DS_CONFIGURED;
                    pend_next  = PK_NONE;
                    act        = ACT_ACK;
                end
            end
            OP_BUS_EVENT:
            begin
                stage_next = ST_SETUP;
                pend_next  = PK_NONE;
                if (item_reg.attached) begin
                    dev_next  = DS_DEFAULT;
                    addr_next = 7'd0;
                end else begin
                    dev_next = DS_NOTATT;
                end
            end
            default:
            begin
                act = ACT_NONE;
            end
        endcase

        // A stall returns ep0 to setup and drops any pending request.
        if (do_stall) begin
            stage_next     = ST_SETUP;
            halted_next[0] = 1'b1;
            pend_next      = PK_NONE;
            act            = ACT_STALL;
            word           = '0;
        end else if (do_finish && stage_next == ST_STATUS) begin
            stage_next = ST_SETUP;
            if (act == ACT_NONE) begin
                act = ACT_ACK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            self_powered_reg     <= 1'b0;
            speed_above_high_reg <= 1'b0;
            function_bound_reg   <= 1'b0;
        end else if (cfg_write) begin
            unique case (cfg_index)
                CFG_SELF_POWERED:     self_powered_reg     <= cfg_data[0];
                CFG_SPEED_ABOVE_HIGH: speed_above_high_reg <= cfg_data[0];
                CFG_FUNCTION_BOUND:   function_bound_reg   <= cfg_data[0];
                default:              self_powered_reg     <= self_powered_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
            stage_reg        <= ST_SETUP;
            dev_reg          <= DS_NOTATT;
            addr_reg         <= 7'd0;
            wake_reg         <= 1'b0;
            halted_reg       <= '0;
            wedged_reg       <= '0;
            pend_reg         <= PK_NONE;
        end else begin
            if (req.valid && req.ready) begin
                item_valid_reg <= 1'b1;
            end else if (advance) begin
                item_valid_reg <= 1'b0;
            end
            if (advance) begin
                result_valid_reg <= 1'b1;
                stage_reg        <= stage_next;
                dev_reg          <= dev_next;
                addr_reg         <= addr_next;
                wake_reg         <= wake_next;
                halted_reg       <= halted_next;
                wedged_reg       <= wedged_next;
                pend_reg         <= pend_next;
            end else if (rsp.ready) begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready) begin
            item_reg <= req.item;
        end
        if (advance) begin
            result_reg.action         <= act;
            result_reg.status_word    <= word;
            result_reg.stage          <= stage_next;
            result_reg.usb_state      <= dev_next;
            result_reg.device_address <= addr_next;
        end
    end

    assign rsp.valid  = result_valid_reg;
    assign rsp.result = result_reg;

    // A stall always leaves ep0 halted and back in the setup stage.
    a_stall_halts: assert property (@(posedge clk) disable iff (!rst_n)
        advance && act == ACT_STALL |=> halted_reg[0] && stage_reg == ST_SETUP)
        else $error("stall did not halt ep0");

    // Forwarded requests must leave something for the software answer to settle.
    a_fwd_pending: assert property (@(posedge clk) disable iff (!rst_n)
        advance && act == ACT_FWD |=> pend_reg != PK_NONE)
        else $error("forwarded request left nothing pending");

    // Status data is only carried by a status word result.
    a_word_only: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.result.action != ACT_WORD |-> rsp.result.status_word == 16'd0)
        else $error("status word set without a status word action");

    // The result shows the stage and device state the handler now holds.
    a_stage_match: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> rsp.result.stage == stage_reg && rsp.result.usb_state == dev_reg)
        else $error("result stage disagrees with handler state");

endmodule
